// ----- design/ssp_pkg.sv -----
package ssp_pkg;

  typedef enum logic [1:0] {
    MODE_PAL_WRITE = 2'd0,
    MODE_DIRECT    = 2'd1,
    MODE_INDEX     = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_STRIDE = 3'd4;

  localparam int STEP_W  = 19;
  localparam int BASE_W  = 22;
  localparam int COL_W   = 12;

  function automatic logic [7:0] rgb332(input logic [15:0] c);
    rgb332 = {c[15:13], c[10:8], c[4:3]};
  endfunction

endpackage

// ----- design/ssp_if.sv -----
interface ssp_in_if;
  import ssp_pkg::*;

  logic        valid;
  logic        ready;
  mode_t       mode;
  logic        first;
  logic [9:0]  line;
  logic [15:0] value;
  logic [7:0]  entry;

  modport source (output valid, output mode, output first, output line, output value,
                  output entry, input ready);
  modport sink (input valid, input mode, input first, input line, input value,
                input entry, output ready);
endinterface

interface ssp_out_if #(
  parameter int ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] addr;
  logic [7:0]           pixel;
  logic                 last;

  modport source (output valid, output addr, output pixel, output last, input ready);
  modport sink (input valid, input addr, input pixel, input last, output ready);
endinterface

// ----- design/ssp_ram.sv -----
module ssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/scanline_scaler_palette.sv -----
// Scanline scaler: takes at most one word per cycle and converts each source pixel
// (RGB565 or palette index) to RGB332 with its framebuffer byte address.
// Downsampling and centred copy give at most one result per word and run
// at one word per cycle while the divider is idle and the output is not
// held; pixel doubling gives two results, and the next word is taken only
// as the second leaves the stage register s1. Palette reads go through a
// synchronous RAM; each result passes s1 and then the output register.
// Every configuration write to a defined index starts a bit-serial divider
// that derives the downsampling step; no word is taken while it runs.
module scanline_scaler_palette #(
  parameter int PALETTE_DEPTH = 256,
  parameter int ADDR_BITS     = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ssp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]     cfg_data,
  ssp_in_if.sink                             pix_in,
  ssp_out_if.source                          pix_out
);
  import ssp_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int FULL_W = (ADDR_BITS > BASE_W + 1) ? ADDR_BITS : BASE_W + 1;
  localparam int DIV_CNT_W = $clog2(STEP_W + 1);

  logic [10:0] src_width;
  logic [10:0] src_height;
  logic [9:0]  frame_width;
  logic [8:0]  frame_height;
  logic [10:0] frame_stride;

  logic [STEP_W-1:0]    step_reg;
  logic                 div_pend;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [STEP_W-1:0]    div_quo;
  logic [9:0]           div_rem;
  logic [9:0]           div_den;
  logic [10:0]          div_trial;
  logic                 div_bit;
  logic [STEP_W-1:0]    div_quo_next;
  logic [9:0]           div_rem_next;
  logic                 busy;

  logic [10:0] src_count;
  logic [18:0] pos_acc;
  logic [9:0]  out_count;

  logic        s1_valid;
  logic        s1_direct;
  logic        s1_idx_ok;
  logic [15:0] s1_value;
  logic [BASE_W-1:0] s1_base;
  logic [COL_W-1:0]  s1_col;
  logic        s1_dbl;
  logic        s1_phase;

  logic        accept;
  logic        is_pixel;
  logic [10:0] sc;
  logic [18:0] pa;
  logic [9:0]  oc;
  logic        in_range;
  logic        down;
  logic        dbl;
  logic        emit;
  logic        centre_v;
  logic [10:0] vdiff;
  logic [10:0] row;
  logic [10:0] hdiff;
  logic [COL_W-1:0]  col;
  logic [BASE_W-1:0] base;
  logic        pal_we;
  logic        pal_re;
  logic [15:0] pal_rdata;
  logic        out_free;
  logic        s1_move;
  logic        s1_done;
  logic [15:0] colour;
  logic [FULL_W-1:0] addr_sum;

  ssp_ram #(.WIDTH(16), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pix_in.entry[PAL_AW-1:0]),
    .wdata (pix_in.value),
    .re    (pal_re),
    .raddr (pix_in.value[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // Step derivation: restoring division of src_width * 256 by frame_width.
  assign busy      = div_pend || (div_cnt != '0);
  assign div_trial = {div_rem, div_quo[STEP_W-1]};
  assign div_bit   = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_bit ? 10'(div_trial - {1'b0, div_den}) : div_trial[9:0];
  assign div_quo_next = {div_quo[STEP_W-2:0], div_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= 11'd320;
      src_height   <= 11'd240;
      frame_width  <= 10'd320;
      frame_height <= 9'd240;
      frame_stride <= 11'd320;
      step_reg     <= 19'd256;
      div_pend     <= 1'b0;
      div_cnt      <= '0;
    end else begin
      if (cfg_we) begin
        div_pend <= 1'b1;
        case (cfg_index)
          CFG_SRC_WIDTH:    src_width    <= cfg_data;
          CFG_SRC_HEIGHT:   src_height   <= cfg_data;
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data[9:0];
          CFG_FRAME_HEIGHT: frame_height <= cfg_data[8:0];
          CFG_FRAME_STRIDE: frame_stride <= cfg_data;
          default:          div_pend     <= div_pend;
        endcase
      end else if (div_pend) begin
        div_pend <= 1'b0;
        div_cnt  <= DIV_CNT_W'(STEP_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DIV_CNT_W'(1)) begin
          step_reg <= div_quo_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_pend && !cfg_we) begin
      div_quo <= {src_width, 8'd0};
      div_rem <= '0;
      div_den <= (frame_width == '0) ? 10'd1 : frame_width;
    end else if (!cfg_we && (div_cnt != '0)) begin
      div_quo <= div_quo_next;
      div_rem <= div_rem_next;
    end
  end

  // Decision and address terms for the incoming word.
  assign is_pixel = (pix_in.mode == MODE_DIRECT) || (pix_in.mode == MODE_INDEX);
  assign sc       = pix_in.first ? '0 : src_count;
  assign pa       = pix_in.first ? '0 : pos_acc;
  assign oc       = pix_in.first ? '0 : out_count;
  assign in_range = sc < src_width;
  assign down     = src_width > {1'b0, frame_width};
  assign dbl      = {src_width, 1'b0} == {2'b00, frame_width};
  assign emit     = is_pixel && in_range &&
                    (!down || ((oc < frame_width) && (pa[18:8] == sc)));

  assign centre_v = (src_height < {2'b00, frame_height}) && (src_height > 11'd2);
  assign vdiff    = {2'b00, frame_height} - src_height;
  assign row      = {1'b0, pix_in.line} + (centre_v ? {1'b0, vdiff[10:1]} : 11'd0);
  assign base     = {11'd0, row} * {11'd0, frame_stride};
  assign hdiff    = {1'b0, frame_width} - src_width;

  always_comb begin
    if (down) begin
      col = {2'b00, oc};
    end else if (dbl) begin
      col = {sc, 1'b0};
    end else begin
      col = {2'b00, hdiff[10:1]} + {1'b0, sc};
    end
  end

  // Output side.
  assign out_free = !pix_out.valid || pix_out.ready;
  assign s1_move  = s1_valid && out_free;
  assign s1_done  = s1_move && (!s1_dbl || s1_phase);
  assign pix_in.ready = !busy && (!s1_valid || s1_done);
  assign accept   = pix_in.valid && pix_in.ready;

  assign pal_we = accept && (pix_in.mode == MODE_PAL_WRITE) &&
                  ({1'b0, pix_in.entry} < 9'(PALETTE_DEPTH));
  assign pal_re = accept && (pix_in.mode == MODE_INDEX) && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_count <= '0;
      pos_acc   <= '0;
      out_count <= '0;
    end else if (accept && is_pixel) begin
      src_count <= sc + 11'd1;
      if (down && emit) begin
        pos_acc   <= pa + step_reg;
        out_count <= oc + 10'd1;
      end else begin
        pos_acc   <= pa;
        out_count <= oc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else if (accept && emit) begin
      s1_valid <= 1'b1;
      s1_phase <= 1'b0;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_direct <= pix_in.mode == MODE_DIRECT;
      s1_idx_ok <= {1'b0, pix_in.value[7:0]} < 9'(PALETTE_DEPTH);
      s1_value  <= pix_in.value;
      s1_base   <= base;
      s1_col    <= col;
      s1_dbl    <= !down && dbl;
    end
  end

  assign colour   = s1_direct ? s1_value : (s1_idx_ok ? pal_rdata : 16'd0);
  assign addr_sum = FULL_W'(s1_base) + FULL_W'(s1_col) + FULL_W'(s1_phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (s1_move) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pix_out.addr  <= addr_sum[ADDR_BITS-1:0];
      pix_out.pixel <= rgb332(colour);
      pix_out.last  <= !s1_dbl || s1_phase;
    end
  end

endmodule
